FILE: rtl/nsfp_pkg.sv
// Package for the NMEA sentence field parser: character codes, sentence kinds,
// field ids and the field lookup used by the data mode.
// No dependencies.
`default_nettype none

package nsfp_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CHAR_V      = 8'h56;  // 'V'
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_C      = 8'h43;

    localparam logic [7:0] TALKER_FIRST_RST  = 8'd71;  // 'G'
    localparam logic [7:0] TALKER_SECOND_RST = 8'd78;  // 'N'

    localparam int unsigned HDR_LEN = 5;

    // sentence kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_GSV  = 2'd2;
    localparam logic [1:0] KIND_RMC  = 2'd3;

    // done mask bits
    localparam logic [2:0] DONE_GGA = 3'b001;
    localparam logic [2:0] DONE_GSV = 3'b010;
    localparam logic [2:0] DONE_RMC = 3'b100;

    // field ids
    localparam logic [3:0] FLD_NONE      = 4'd0;
    localparam logic [3:0] FLD_LAT       = 4'd1;
    localparam logic [3:0] FLD_LAT_HEMI  = 4'd2;
    localparam logic [3:0] FLD_LON       = 4'd3;
    localparam logic [3:0] FLD_LON_HEMI  = 4'd4;
    localparam logic [3:0] FLD_FIX       = 4'd5;
    localparam logic [3:0] FLD_SATS_USED = 4'd6;
    localparam logic [3:0] FLD_ALTITUDE  = 4'd7;
    localparam logic [3:0] FLD_SATS_VIEW = 4'd8;
    localparam logic [3:0] FLD_TIME      = 4'd9;
    localparam logic [3:0] FLD_SPEED     = 4'd10;
    localparam logic [3:0] FLD_COURSE    = 4'd11;
    localparam logic [3:0] FLD_DATE      = 4'd12;

    // register indexes on the config port
    localparam logic REG_TALKER_FIRST  = 1'b0;
    localparam logic REG_TALKER_SECOND = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_HEADER = 3'b010,
        MODE_DATA   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [3:0] id;
        logic [3:0] len;   // capture length, 0 when not tracked
    } field_t;

    function automatic field_t field_of(input logic [1:0] kind, input logic [7:0] seg);
        field_t f;
        f = '{id: FLD_NONE, len: 4'd0};
        case (kind)
            KIND_GGA:
            begin
                case (seg)
                    8'd2:    f = '{id: FLD_LAT,       len: 4'd9};
                    8'd3:    f = '{id: FLD_LAT_HEMI,  len: 4'd1};
                    8'd4:    f = '{id: FLD_LON,       len: 4'd10};
                    8'd5:    f = '{id: FLD_LON_HEMI,  len: 4'd1};
                    8'd6:    f = '{id: FLD_FIX,       len: 4'd1};
                    8'd7:    f = '{id: FLD_SATS_USED, len: 4'd2};
                    8'd9:    f = '{id: FLD_ALTITUDE,  len: 4'd6};
                    default: f = '{id: FLD_NONE,      len: 4'd0};
                endcase
            end
            KIND_GSV:
            begin
                if (seg == 8'd3)
                begin
                    f = '{id: FLD_SATS_VIEW, len: 4'd2};
                end
            end
            KIND_RMC:
            begin
                case (seg)
                    8'd1:    f = '{id: FLD_TIME,      len: 4'd6};
                    8'd2:    f = '{id: FLD_FIX,       len: 4'd1};
                    8'd3:    f = '{id: FLD_LAT,       len: 4'd9};
                    8'd4:    f = '{id: FLD_LAT_HEMI,  len: 4'd1};
                    8'd5:    f = '{id: FLD_LON,       len: 4'd10};
                    8'd6:    f = '{id: FLD_LON_HEMI,  len: 4'd1};
                    8'd7:    f = '{id: FLD_SPEED,     len: 4'd5};
                    8'd8:    f = '{id: FLD_COURSE,    len: 4'd5};
                    8'd9:    f = '{id: FLD_DATE,      len: 4'd6};
                    default: f = '{id: FLD_NONE,      len: 4'd0};
                endcase
            end
            default: f = '{id: FLD_NONE, len: 4'd0};
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nmea_sentence_field_parser.sv
// NMEA sentence field parser: one received character per item, one result per item.
// The result is registered when the item is accepted.
// Throughput: one item per cycle; the input stalls only while a result waits on out_ready.
// Reset clears mode, counters, kind, lock, done and seen bits and sets the talker registers to 'G' and 'N';
// the five-byte header store is not reset.
// Depends on nsfp_pkg.
`default_nettype none

module nmea_sentence_field_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // results
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             sentence_start,
    output logic             sentence_end,
    output logic [1:0]       sentence_kind,
    output logic [3:0]       field_id,
    output logic [3:0]       char_pos,
    output logic [7:0]       char_value,
    output logic [2:0]       done_mask,
    output logic [7:0]       fix_lock,
    output logic             data_seen,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned HL = nsfp_pkg::HDR_LEN;

    // config registers
    logic [7:0] talker_first_reg;
    logic [7:0] talker_second_reg;

    // parser state
    nsfp_pkg::mode_t mode_reg, mode_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] comma_count_reg, comma_count_next;
    logic [7:0] char_count_reg, char_count_next;
    logic [7:0] lock_reg, lock_next;
    logic [2:0] done_reg, done_next;
    logic       seen_reg, seen_next;
    logic [7:0] hdr_reg [HL];
    logic [7:0] hdr_view [HL];
    logic       hdr_we;

    // output register
    logic       out_valid_reg;
    logic       start_reg, start_next;
    logic       end_reg, end_next;
    logic [3:0] fid_reg, fid_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] val_reg, val_next;

    logic              accept;
    logic              cfg_wr;
    logic [1:0]        match_kind;
    nsfp_pkg::field_t  fld;

    assign pready   = 1'b1;
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == nsfp_pkg::REG_TALKER_FIRST)
        begin
            prdata = {24'd0, talker_first_reg};
        end
        else
        begin
            prdata = {24'd0, talker_second_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            talker_first_reg  <= nsfp_pkg::TALKER_FIRST_RST;
            talker_second_reg <= nsfp_pkg::TALKER_SECOND_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == nsfp_pkg::REG_TALKER_FIRST)
            begin
                talker_first_reg <= pwdata[7:0];
            end
            else
            begin
                talker_second_reg <= pwdata[7:0];
            end
        end
    end

    // header as it stands after this byte is stored
    assign hdr_we = (mode_reg == nsfp_pkg::MODE_HEADER) && (char_count_reg < 8'(HL))
                    && (rx_byte != nsfp_pkg::CHAR_DOLLAR) && (rx_byte != nsfp_pkg::CHAR_COMMA)
                    && (rx_byte != nsfp_pkg::CHAR_STAR);

    always_comb
    begin
        for (int i = 0; i < HL; i++)
        begin
            hdr_view[i] = (hdr_we && char_count_reg == 8'(i)) ? rx_byte : hdr_reg[i];
        end
    end

    always_comb
    begin
        match_kind = nsfp_pkg::KIND_NONE;
        if (hdr_view[0] == talker_first_reg && hdr_view[1] == talker_second_reg)
        begin
            if (hdr_view[2] == nsfp_pkg::CHAR_G && hdr_view[3] == nsfp_pkg::CHAR_G
                && hdr_view[4] == nsfp_pkg::CHAR_A)
            begin
                match_kind = nsfp_pkg::KIND_GGA;
            end
            else if (hdr_view[2] == nsfp_pkg::CHAR_G && hdr_view[3] == nsfp_pkg::CHAR_S
                     && hdr_view[4] == nsfp_pkg::CHAR_V)
            begin
                match_kind = nsfp_pkg::KIND_GSV;
            end
            else if (hdr_view[2] == nsfp_pkg::CHAR_R && hdr_view[3] == nsfp_pkg::CHAR_M
                     && hdr_view[4] == nsfp_pkg::CHAR_C)
            begin
                match_kind = nsfp_pkg::KIND_RMC;
            end
        end
    end

    assign fld = nsfp_pkg::field_of(kind_reg, comma_count_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        kind_next        = kind_reg;
        comma_count_next = comma_count_reg;
        char_count_next  = char_count_reg;
        lock_next        = lock_reg;
        done_next        = done_reg;
        seen_next        = seen_reg;
        start_next       = 1'b0;
        end_next         = 1'b0;
        fid_next         = nsfp_pkg::FLD_NONE;
        pos_next         = 4'd0;
        val_next         = 8'd0;

        if (rx_byte == nsfp_pkg::CHAR_DOLLAR)
        begin
            start_next      = 1'b1;
            kind_next       = nsfp_pkg::KIND_NONE;
            mode_next       = nsfp_pkg::MODE_HEADER;
            char_count_next = 8'd0;
            seen_next       = 1'b1;
        end
        else if (rx_byte == nsfp_pkg::CHAR_COMMA)
        begin
            comma_count_next = comma_count_reg + 8'd1;
            char_count_next  = 8'd0;
        end
        else if (rx_byte == nsfp_pkg::CHAR_STAR)
        begin
            end_next  = 1'b1;
            mode_next = nsfp_pkg::MODE_IDLE;
            case (kind_reg)
                nsfp_pkg::KIND_GGA: done_next = done_reg | nsfp_pkg::DONE_GGA;
                nsfp_pkg::KIND_GSV: done_next = done_reg | nsfp_pkg::DONE_GSV;
                nsfp_pkg::KIND_RMC: done_next = done_reg | nsfp_pkg::DONE_RMC;
                default:            done_next = done_reg;
            endcase
        end
        else
        begin
            // saturating count; a header match below restarts it at one
            char_count_next = (char_count_reg == 8'hFF) ? char_count_reg
                                                          : char_count_reg + 8'd1;
            case (mode_reg)
                nsfp_pkg::MODE_HEADER:
                begin
                    if (char_count_reg >= 8'(HL - 1) && match_kind != nsfp_pkg::KIND_NONE)
                    begin
                        kind_next        = match_kind;
                        mode_next        = nsfp_pkg::MODE_DATA;
                        comma_count_next = 8'd0;
                        char_count_next  = 8'd1;
                    end
                end
                nsfp_pkg::MODE_DATA:
                begin
                    if (fld.id != nsfp_pkg::FLD_NONE && char_count_reg < {4'd0, fld.len})
                    begin
                        fid_next = fld.id;
                        pos_next = char_count_reg[3:0];
                        val_next = rx_byte;
                        if (fld.id == nsfp_pkg::FLD_FIX)
                        begin
                            if (kind_reg == nsfp_pkg::KIND_GGA)
                            begin
                                lock_next = rx_byte;
                            end
                            else
                            begin
                                lock_next = {7'd0, rx_byte != nsfp_pkg::CHAR_V};
                            end
                        end
                    end
                end
                default:
                begin
                    // idle: only the count moves
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= nsfp_pkg::MODE_IDLE;
            kind_reg        <= nsfp_pkg::KIND_NONE;
            comma_count_reg <= 8'd0;
            char_count_reg  <= 8'd0;
            lock_reg        <= 8'd0;
            done_reg        <= 3'd0;
            seen_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                kind_reg        <= kind_next;
                comma_count_reg <= comma_count_next;
                char_count_reg  <= char_count_next;
                lock_reg        <= lock_next;
                done_reg        <= done_next;
                seen_reg        <= seen_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: header store and per-item result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (hdr_we)
            begin
                hdr_reg[char_count_reg[2:0]] <= rx_byte;
            end
            start_reg <= start_next;
            end_reg   <= end_next;
            fid_reg   <= fid_next;
            pos_reg   <= pos_next;
            val_reg   <= val_next;
        end
    end

    // kind, done, lock and seen are the state after the item
    assign out_valid      = out_valid_reg;
    assign sentence_start = start_reg;
    assign sentence_end   = end_reg;
    assign sentence_kind  = kind_reg;
    assign field_id       = fid_reg;
    assign char_pos       = pos_reg;
    assign char_value     = val_reg;
    assign done_mask      = done_reg;
    assign fix_lock       = lock_reg;
    assign data_seen      = seen_reg;

endmodule

`default_nettype wire

FILE: dv/nmea_sentence_field_parser_test.sv
// Testbench for the NMEA sentence field parser: directed table then random sentences,
// each result checked against an in-bench parse predictor or a typed expectation, over several talker settings.
// Depends on nsfp_pkg and nmea_sentence_field_parser.
`default_nettype none

module nmea_sentence_field_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 120;
    localparam logic [2:0] ADDR_TALKER_FIRST  = {nsfp_pkg::REG_TALKER_FIRST, 2'b00};
    localparam logic [2:0] ADDR_TALKER_SECOND = {nsfp_pkg::REG_TALKER_SECOND, 2'b00};

    typedef struct packed {
        logic       start_flag;
        logic       end_flag;
        logic [1:0] kind;
        logic [3:0] fld;
        logic [3:0] pos;
        logic [7:0] val;
        logic [2:0] done;
        logic [7:0] lock;
        logic       seen;
    } parse_result_t;

    typedef struct packed {
        logic [3:0] id;
        logic [3:0] len;
    } slot_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        sentence_start;
    logic        sentence_end;
    logic [1:0]  sentence_kind;
    logic [3:0]  field_id;
    logic [3:0]  char_pos;
    logic [7:0]  char_value;
    logic [2:0]  done_mask;
    logic [7:0]  fix_lock;
    logic        data_seen;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nmea_sentence_field_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sentence_start (sentence_start),
        .sentence_end   (sentence_end),
        .sentence_kind  (sentence_kind),
        .field_id       (field_id),
        .char_pos       (char_pos),
        .char_value     (char_value),
        .done_mask      (done_mask),
        .fix_lock       (fix_lock),
        .data_seen      (data_seen),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // predictor state
    logic [7:0]       talk1_q;
    logic [7:0]       talk2_q;
    nsfp_pkg::mode_t  mode_q;
    logic [1:0]       kind_q;
    logic [7:0]       commas_q;
    logic [7:0]       chars_q;
    logic [7:0]       hdr_q [0:4];
    logic [7:0]       lock_q;
    logic [2:0]       done_q;
    logic             seen_q;

    parse_result_t expected_results [$];
    logic [7:0]    row_bytes [$];
    bit            row_typed [$];
    parse_result_t row_want [$];

    int errors;
    int cycles;
    int items_sent;
    int results_checked;
    int settings_used;
    int sentences_closed [1:3];
    int idle_pct;
    int stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
        begin
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                report("result with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("sentence_start", 8'(sentence_start), 8'(want.start_flag));
                check_field("sentence_end", 8'(sentence_end), 8'(want.end_flag));
                check_field("sentence_kind", 8'(sentence_kind), 8'(want.kind));
                check_field("field_id", 8'(field_id), 8'(want.fld));
                check_field("char_pos", 8'(char_pos), 8'(want.pos));
                check_field("char_value", char_value, want.val);
                check_field("done_mask", 8'(done_mask), 8'(want.done));
                check_field("fix_lock", fix_lock, want.lock);
                check_field("data_seen", 8'(data_seen), 8'(want.seen));
            end
        end
    end

    function automatic slot_t field_slot(input logic [1:0] kind, input logic [7:0] seg);
        slot_t s;
        s = '{id: nsfp_pkg::FLD_NONE, len: 4'd0};
        if (kind == nsfp_pkg::KIND_GGA)
        begin
            case (seg)
                8'd2: s = '{id: nsfp_pkg::FLD_LAT,       len: 4'd9};
                8'd3: s = '{id: nsfp_pkg::FLD_LAT_HEMI,  len: 4'd1};
                8'd4: s = '{id: nsfp_pkg::FLD_LON,       len: 4'd10};
                8'd5: s = '{id: nsfp_pkg::FLD_LON_HEMI,  len: 4'd1};
                8'd6: s = '{id: nsfp_pkg::FLD_FIX,       len: 4'd1};
                8'd7: s = '{id: nsfp_pkg::FLD_SATS_USED, len: 4'd2};
                8'd9: s = '{id: nsfp_pkg::FLD_ALTITUDE,  len: 4'd6};
                default: ;
            endcase
        end
        else if (kind == nsfp_pkg::KIND_GSV)
        begin
            if (seg == 8'd3)
            begin
                s = '{id: nsfp_pkg::FLD_SATS_VIEW, len: 4'd2};
            end
        end
        else if (kind == nsfp_pkg::KIND_RMC)
        begin
            case (seg)
                8'd1: s = '{id: nsfp_pkg::FLD_TIME,      len: 4'd6};
                8'd2: s = '{id: nsfp_pkg::FLD_FIX,       len: 4'd1};
                8'd3: s = '{id: nsfp_pkg::FLD_LAT,       len: 4'd9};
                8'd4: s = '{id: nsfp_pkg::FLD_LAT_HEMI,  len: 4'd1};
                8'd5: s = '{id: nsfp_pkg::FLD_LON,       len: 4'd10};
                8'd6: s = '{id: nsfp_pkg::FLD_LON_HEMI,  len: 4'd1};
                8'd7: s = '{id: nsfp_pkg::FLD_SPEED,     len: 4'd5};
                8'd8: s = '{id: nsfp_pkg::FLD_COURSE,    len: 4'd5};
                8'd9: s = '{id: nsfp_pkg::FLD_DATE,      len: 4'd6};
                default: ;
            endcase
        end
        return s;
    endfunction

    function automatic logic [1:0] header_kind();
        if (hdr_q[0] != talk1_q || hdr_q[1] != talk2_q)
        begin
            return nsfp_pkg::KIND_NONE;
        end
        if (hdr_q[2] == nsfp_pkg::CHAR_G && hdr_q[3] == nsfp_pkg::CHAR_G
            && hdr_q[4] == nsfp_pkg::CHAR_A)
        begin
            return nsfp_pkg::KIND_GGA;
        end
        if (hdr_q[2] == nsfp_pkg::CHAR_G && hdr_q[3] == nsfp_pkg::CHAR_S
            && hdr_q[4] == nsfp_pkg::CHAR_V)
        begin
            return nsfp_pkg::KIND_GSV;
        end
        if (hdr_q[2] == nsfp_pkg::CHAR_R && hdr_q[3] == nsfp_pkg::CHAR_M
            && hdr_q[4] == nsfp_pkg::CHAR_C)
        begin
            return nsfp_pkg::KIND_RMC;
        end
        return nsfp_pkg::KIND_NONE;
    endfunction

    // advances the parse state by one character and gives the result it causes
    task automatic parse_char(input logic [7:0] b, output parse_result_t r);
        slot_t      s;
        logic [1:0] k;
        r = '0;
        if (b == nsfp_pkg::CHAR_DOLLAR)
        begin
            r.start_flag = 1'b1;
            kind_q = nsfp_pkg::KIND_NONE;
            mode_q = nsfp_pkg::MODE_HEADER;
            chars_q = 8'd0;
            seen_q = 1'b1;
        end
        else if (b == nsfp_pkg::CHAR_COMMA)
        begin
            commas_q = commas_q + 8'd1;
            chars_q = 8'd0;
        end
        else if (b == nsfp_pkg::CHAR_STAR)
        begin
            r.end_flag = 1'b1;
            case (kind_q)
                nsfp_pkg::KIND_GGA: done_q = done_q | nsfp_pkg::DONE_GGA;
                nsfp_pkg::KIND_GSV: done_q = done_q | nsfp_pkg::DONE_GSV;
                nsfp_pkg::KIND_RMC: done_q = done_q | nsfp_pkg::DONE_RMC;
                default: ;
            endcase
            if (kind_q != nsfp_pkg::KIND_NONE)
            begin
                sentences_closed[kind_q]++;
            end
            mode_q = nsfp_pkg::MODE_IDLE;
        end
        else
        begin
            if (mode_q == nsfp_pkg::MODE_HEADER)
            begin
                // bytes past the fifth are dropped; the match reruns on the stored five
                if (chars_q < nsfp_pkg::HDR_LEN)
                begin
                    hdr_q[chars_q[2:0]] = b;
                end
                if (chars_q >= 8'd4)
                begin
                    k = header_kind();
                    if (k != nsfp_pkg::KIND_NONE)
                    begin
                        kind_q = k;
                        mode_q = nsfp_pkg::MODE_DATA;
                        commas_q = 8'd0;
                        chars_q = 8'd0;
                    end
                end
            end
            else if (mode_q == nsfp_pkg::MODE_DATA)
            begin
                s = field_slot(kind_q, commas_q);
                if (s.id != nsfp_pkg::FLD_NONE && chars_q < {4'd0, s.len})
                begin
                    r.fld = s.id;
                    r.pos = chars_q[3:0];
                    r.val = b;
                    if (s.id == nsfp_pkg::FLD_FIX)
                    begin
                        if (kind_q == nsfp_pkg::KIND_GGA)
                        begin
                            lock_q = b;
                        end
                        else
                        begin
                            lock_q = (b == nsfp_pkg::CHAR_V) ? 8'd0 : 8'd1;
                        end
                    end
                end
            end
            if (chars_q != 8'hFF)
            begin
                chars_q = chars_q + 8'd1;
            end
        end
        r.kind = kind_q;
        r.done = done_q;
        r.lock = lock_q;
        r.seen = seen_q;
    endtask

    // typed expectation, used where it overrides the predictor
    task automatic send_checked(input logic [7:0] b, input bit typed, input parse_result_t want);
        int            gap;
        parse_result_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        parse_char(b, r);
        expected_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic send(input logic [7:0] b);
        send_checked(b, 1'b0, '0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send(s[i]);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        logic [31:0] word;
        word = $urandom();
        word[7:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        // paddr still selects the register just written
        if (prdata !== {24'd0, value} || pready !== 1'b1)
        begin
            report($sformatf("read back of %0h gave %0h", addr, prdata));
        end
        if (addr == ADDR_TALKER_FIRST)
        begin
            talk1_q = value;
        end
        else
        begin
            talk2_q = value;
        end
    endtask

    task automatic set_talker(input logic [7:0] first, input logic [7:0] second);
        drain();
        write_reg(ADDR_TALKER_FIRST, first);
        write_reg(ADDR_TALKER_SECOND, second);
        settings_used++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(255));
        end
        while (c == nsfp_pkg::CHAR_DOLLAR || c == nsfp_pkg::CHAR_COMMA
               || c == nsfp_pkg::CHAR_STAR);
        return c;
    endfunction

    function automatic logic [7:0] field_char();
        string picks;
        int    r;
        picks = "VANSEW.";
        r = $urandom_range(99);
        if (r < 60)
        begin
            return 8'h30 + 8'($urandom_range(9));
        end
        if (r < 75)
        begin
            return picks[$urandom_range(picks.len() - 1)];
        end
        return plain_char();
    endfunction

    task automatic send_sentence();
        string      hexd;
        int         nf;
        int         len;
        logic [7:0] t1;
        logic [7:0] t2;
        hexd = "0123456789ABCDEF";
        t1 = talk1_q;
        t2 = talk2_q;
        if ($urandom_range(9) == 0)
        begin
            t1 = plain_char();
        end
        if ($urandom_range(9) == 0)
        begin
            t2 = plain_char();
        end
        send(nsfp_pkg::CHAR_DOLLAR);
        send(t1);
        send(t2);
        case ($urandom_range(9))
            0, 1, 2: send_text("GGA");
            3, 4:    send_text("GSV");
            5, 6, 7: send_text("RMC");
            default:
            begin
                // broken header: G followed by two random characters
                send(nsfp_pkg::CHAR_G);
                send(plain_char());
                send(plain_char());
            end
        endcase
        nf = $urandom_range(12);
        repeat (nf)
        begin
            send(nsfp_pkg::CHAR_COMMA);
            len = $urandom_range(11);
            repeat (len) send(field_char());
        end
        if ($urandom_range(9) != 0)
        begin
            send(nsfp_pkg::CHAR_STAR);
            send(hexd[$urandom_range(15)]);
            send(hexd[$urandom_range(15)]);
        end
        if ($urandom_range(1) == 0)
        begin
            send(8'h0D);
            send(8'h0A);
        end
    endtask

    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 20);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 7)
            begin
                send(nsfp_pkg::CHAR_DOLLAR);
            end
            else if (r < 14)
            begin
                send(nsfp_pkg::CHAR_COMMA);
            end
            else if (r < 20)
            begin
                send(nsfp_pkg::CHAR_STAR);
            end
            else
            begin
                send(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                send_sentence();
            end
            else
            begin
                send_noise();
            end
            // sender holds off until the pipe is empty
            if ($urandom_range(24) == 0)
            begin
                drain();
            end
        end
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input parse_result_t want);
        row_bytes.push_back(b);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    task automatic add_text_rows(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_row(s[i], 1'b0, '0);
        end
    endtask

    function automatic parse_result_t flags_only(input logic start_flag, input logic end_flag,
                                                 input logic seen);
        parse_result_t r;
        r = '0;
        r.start_flag = start_flag;
        r.end_flag = end_flag;
        r.seen = seen;
        return r;
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= 8'd0;
        out_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'd0;
        pwdata <= 32'd0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        results_checked = 0;
        settings_used = 1;
        sentences_closed = '{0, 0, 0};
        idle_pct = 0;
        stall_pct = 0;
        talk1_q = nsfp_pkg::TALKER_FIRST_RST;
        talk2_q = nsfp_pkg::TALKER_SECOND_RST;
        mode_q = nsfp_pkg::MODE_IDLE;
        kind_q = nsfp_pkg::KIND_NONE;
        commas_q = 8'd0;
        chars_q = 8'd0;
        lock_q = 8'd0;
        done_q = 3'd0;
        seen_q = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            hdr_q[i] = 8'd0;
        end

        // directed: extremes and terminators from reset, then one fix each for GGA and RMC
        add_row(8'h00, 1'b1, flags_only(1'b0, 1'b0, 1'b0));
        add_row(8'hFF, 1'b1, flags_only(1'b0, 1'b0, 1'b0));
        add_row(nsfp_pkg::CHAR_STAR, 1'b1, flags_only(1'b0, 1'b1, 1'b0));
        add_row(nsfp_pkg::CHAR_COMMA, 1'b1, flags_only(1'b0, 1'b0, 1'b0));
        add_row(nsfp_pkg::CHAR_DOLLAR, 1'b1, flags_only(1'b1, 1'b0, 1'b1));
        add_text_rows("GNGGA,,,,,,V*");
        add_text_rows("$GNRMC,,V*");

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < row_bytes.size(); i++)
        begin
            send_checked(row_bytes[i], row_typed[i], row_want[i]);
        end

        run_phase(0, 0);

        set_talker(nsfp_pkg::CHAR_G, 8'h50);
        run_phase(51, 0);

        set_talker(8'h00, 8'hFF);
        // a long time field pushes the character count into saturation
        idle_pct = 0;
        send(nsfp_pkg::CHAR_DOLLAR);
        send(8'h00);
        send(8'hFF);
        send_text("RMC,");
        repeat (280) send(8'h30 + 8'($urandom_range(9)));
        send(nsfp_pkg::CHAR_STAR);
        run_phase(0, 51);

        set_talker(8'hFF, 8'h00);
        // field counter wraps back onto the satellites-in-view field
        idle_pct = 20;
        send(nsfp_pkg::CHAR_DOLLAR);
        send(8'hFF);
        send(8'h00);
        send_text("GSV");
        repeat (259) send(nsfp_pkg::CHAR_COMMA);
        send_text("12*");
        run_phase(38, 38);

        set_talker(nsfp_pkg::TALKER_FIRST_RST, nsfp_pkg::TALKER_SECOND_RST);
        run_phase(38, 38);

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d items and %0d results over %0d talker settings",
                 items_sent, results_checked, settings_used);
        $display("sentences closed: GGA %0d, GSV %0d, RMC %0d; %0d mismatches",
                 sentences_closed[1], sentences_closed[2], sentences_closed[3], errors);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
